// ----- hw/rtl/mbrb_pkg.sv -----
// Package for the mirror-bit ring buffer: payload structs, operation codes,
// controller states and the fill-count helper. Depends on nothing.
package mbrb_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_FORCE = 2'd1,
        OP_GET   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
        logic       dropped_oldest;
        logic [8:0] fill_level;
        logic       is_empty;
        logic       is_full;
    } t_res_item;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;   // take the item and prefetch the oldest byte
        logic exec;   // commit the operation and register the result
    } t_cmd;

    localparam logic [8:0] CAP_RESET = 9'd256;

    // Bytes held, from positions and mirror bits.
    function automatic logic [8:0] fill_count(
        input logic [8:0] wp,
        input logic [8:0] rp,
        input logic       ww,
        input logic       rw,
        input logic [8:0] cap
    );
        logic [8:0] level;
        if (wp == rp) begin
            level = (ww == rw) ? 9'd0 : cap;
        end else if (wp > rp) begin
            level = wp - rp;
        end else begin
            level = cap - (rp - wp);
        end
        return level;
    endfunction

endpackage

// ----- hw/rtl/mbrb_ctrl.sv -----
// Controller state machine of the ring buffer: sequences load and execute.
// Depends on mbrb_pkg.
module mbrb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output mbrb_pkg::t_cmd o_cmd,
    output logic          o_res_strobe
);

    mbrb_pkg::t_state r_state;
    mbrb_pkg::t_state n_state;
    logic             r_strobe;
    logic             n_strobe;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mbrb_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = mbrb_pkg::ST_EXEC;
                end
            end
            mbrb_pkg::ST_EXEC: begin
                n_state = mbrb_pkg::ST_IDLE;
            end
            default: begin
                n_state = mbrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        busy       = 1'b0;
        case (r_state)
            mbrb_pkg::ST_IDLE: begin
                o_cmd.load = start;
            end
            mbrb_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                busy       = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign n_strobe     = o_cmd.exec;
    assign o_res_strobe = r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mbrb_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

endmodule

// ----- hw/rtl/mbrb_dpath.sv -----
// Datapath of the ring buffer: byte store, positions with mirror bits,
// capacity register and result register. Depends on mbrb_pkg.
module mbrb_dpath #(
    parameter int DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [8:0]           i_cfg_data,
    input  mbrb_pkg::t_cmd       i_cmd,
    input  mbrb_pkg::t_in_item   i_in_item,
    output mbrb_pkg::t_res_item  o_res_item
);

    // The store holds at most 256 slots; a larger capacity saturates to the store size.
    localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [8:0] CAP_MAX = 9'(MEM_DEPTH);

    logic [7:0]          r_mem [0:MEM_DEPTH-1];
    logic [AW-1:0]       r_wr_pos, n_wr_pos;
    logic [AW-1:0]       r_rd_pos, n_rd_pos;
    logic                r_wr_wrap, n_wr_wrap;
    logic                r_rd_wrap, n_rd_wrap;
    logic [8:0]          r_cap;
    mbrb_pkg::t_op       r_op;
    logic [7:0]          r_data;
    logic [7:0]          r_rd_byte;
    mbrb_pkg::t_res_item r_res, n_res;

    logic [8:0] ecap;
    logic [8:0] wp9, rp9;
    logic [8:0] level_pre, level_post;
    logic       wr_last, rd_last;
    logic       mem_we;

    always_comb begin
        ecap = (r_cap == 9'd0) ? 9'd1 : r_cap;
        if (ecap > CAP_MAX) begin
            ecap = CAP_MAX;
        end
    end

    assign wp9       = 9'(r_wr_pos);
    assign rp9       = 9'(r_rd_pos);
    assign wr_last   = (wp9 + 9'd1) >= ecap;
    assign rd_last   = (rp9 + 9'd1) >= ecap;
    assign level_pre = mbrb_pkg::fill_count(wp9, rp9, r_wr_wrap, r_rd_wrap, ecap);

    always_comb begin
        n_wr_pos  = r_wr_pos;
        n_rd_pos  = r_rd_pos;
        n_wr_wrap = r_wr_wrap;
        n_rd_wrap = r_rd_wrap;
        mem_we    = 1'b0;
        n_res     = '0;
        case (r_op)
            mbrb_pkg::OP_PUT: begin
                if (level_pre < ecap) begin
                    mem_we         = 1'b1;
                    n_wr_pos       = wr_last ? '0 : r_wr_pos + 1'b1;
                    n_wr_wrap      = r_wr_wrap ^ wr_last;
                    n_res.done_res = 1'b1;
                end
            end
            mbrb_pkg::OP_FORCE: begin
                mem_we         = 1'b1;
                n_wr_pos       = wr_last ? '0 : r_wr_pos + 1'b1;
                n_wr_wrap      = r_wr_wrap ^ wr_last;
                n_res.done_res = 1'b1;
                // Full: push the read side along with the write side.
                if (level_pre == ecap) begin
                    n_rd_pos             = n_wr_pos;
                    n_rd_wrap            = r_rd_wrap ^ wr_last;
                    n_res.dropped_oldest = 1'b1;
                end
            end
            mbrb_pkg::OP_GET: begin
                if (level_pre != 9'd0) begin
                    n_rd_pos        = rd_last ? '0 : r_rd_pos + 1'b1;
                    n_rd_wrap       = r_rd_wrap ^ rd_last;
                    n_res.read_data = r_rd_byte;
                    n_res.done_res  = 1'b1;
                end
            end
            mbrb_pkg::OP_CLEAR: begin
                n_wr_pos  = '0;
                n_rd_pos  = '0;
                n_wr_wrap = 1'b0;
                n_rd_wrap = 1'b0;
            end
            default: begin
            end
        endcase
        level_post = mbrb_pkg::fill_count(9'(n_wr_pos), 9'(n_rd_pos),
                                          n_wr_wrap, n_rd_wrap, ecap);
        n_res.fill_level = level_post;
        n_res.is_empty   = (level_post == 9'd0);
        n_res.is_full    = (level_post == ecap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos  <= '0;
            r_rd_pos  <= '0;
            r_wr_wrap <= 1'b0;
            r_rd_wrap <= 1'b0;
            r_cap     <= mbrb_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap     <= i_cfg_data;
            r_wr_pos  <= '0;
            r_rd_pos  <= '0;
            r_wr_wrap <= 1'b0;
            r_rd_wrap <= 1'b0;
        end else if (i_cmd.exec) begin
            r_wr_pos  <= n_wr_pos;
            r_rd_pos  <= n_rd_pos;
            r_wr_wrap <= n_wr_wrap;
            r_rd_wrap <= n_rd_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_in_item.op;
            r_data    <= i_in_item.data_in;
            r_rd_byte <= r_mem[r_rd_pos];
        end
        if (i_cmd.exec && mem_we) begin
            r_mem[r_wr_pos] <= r_data;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_res_item = r_res;

endmodule

// ----- hw/rtl/mirror_bit_ring_buffer_unit.sv -----
// Top level of the mirror-bit ring buffer byte FIFO.
// Depends on mbrb_pkg, mbrb_ctrl and mbrb_dpath.
//
// Usage:
//   Command channel: raise start with i_in_item (op, data_in); the transfer
//   happens at the rising edge where start is high and busy is low.
//   Operations: put, forced put (drops the oldest byte when full), get,
//   and clear positions.
//   Result channel: o_res_item is valid for exactly one cycle while
//   o_res_strobe is high; the receiver cannot stall, so take it then.
//   Configuration: pulse i_cfg_we with i_cfg_data to set the capacity in
//   use (zero acts as one, values above the store size saturate). A write
//   also empties the FIFO. Write it only while the block is idle.
// Timing:
//   An accepted item moves the controller to its execute state, where busy
//   is high; the result register and o_res_strobe are loaded from it. The
//   block takes no new item until the last one is through: first the oldest
//   byte is read from the registered store port, then the operation is
//   committed and the result registered. A new item may be accepted in the
//   same cycle its predecessor's result is shown.
// Reset: synchronous, active low; empties the FIFO, sets capacity to 256,
//   and drops any item in flight. Store contents are not cleared.
module mirror_bit_ring_buffer_unit #(
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  mbrb_pkg::t_in_item  i_in_item,
    output logic                o_res_strobe,
    output mbrb_pkg::t_res_item o_res_item
);

    mbrb_pkg::t_cmd cmd;

    // Sequence each transfer: load, then execute.
    mbrb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .o_cmd        (cmd),
        .o_res_strobe (o_res_strobe)
    );

    // Hold the store, positions and capacity; build the result.
    mbrb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_res_item (o_res_item)
    );

endmodule

// ----- hw/rtl/mbrb_checker.sv -----
// Port-level checker for the ring buffer and its bind to the top level.
// Depends on mbrb_pkg and mirror_bit_ring_buffer_unit.
module mbrb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_res_strobe,
    input mbrb_pkg::t_res_item o_res_item
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result without a transfer in progress");

    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (o_res_item.is_empty == (o_res_item.fill_level == 9'd0)))
        else $error("empty flag disagrees with fill level");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res_item.done_res) |-> (o_res_item.read_data == 8'd0))
        else $error("data returned by a failed operation");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res_item.dropped_oldest)
            |-> (o_res_item.is_full && o_res_item.done_res))
        else $error("dropped oldest byte but not full after forced put");

endmodule

bind mirror_bit_ring_buffer_unit mbrb_checker u_mbrb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_res_item   (o_res_item)
);
